FILE: hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // Fixed field and cursor widths
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned LOC_W  = 11;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CELL_W = 16;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  // Blank cell: white on black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [7:0]       char_code;
    logic [3:0]       bg_color;
    logic [3:0]       fg_color;
    logic [IDX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } result_t;

  // Cursor update for one put
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr_en;
    logic             scroll;
  } cur_step_t;

endpackage

FILE: hdl/tcw_screen_ram.sv
`timescale 1ns / 1ps

module tcw_screen_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic [tcw_pkg::COL_W-1:0] col_i,
  input  logic [tcw_pkg::ROW_W-1:0] row_i,
  input  logic [7:0]                code_i,
  output tcw_pkg::cur_step_t        step_o
);

  logic [tcw_pkg::COL_W:0] col_w;
  logic [tcw_pkg::ROW_W:0] row_w;
  logic                    wr_en;
  logic                    scroll;

  always_comb begin
    col_w  = {1'b0, col_i};
    row_w  = {1'b0, row_i};
    wr_en  = 1'b0;
    scroll = 1'b0;

    // Control codes and printable characters
    if (code_i == tcw_pkg::CH_BS) begin
      if (col_i != '0) begin
        col_w = col_w - 1'b1;
      end
    end else if (code_i == tcw_pkg::CH_TAB) begin
      col_w = (col_w + (tcw_pkg::COL_W+1)'(8)) & ~(tcw_pkg::COL_W+1)'(7);
    end else if (code_i == tcw_pkg::CH_CR) begin
      col_w = '0;
    end else if (code_i == tcw_pkg::CH_LF) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end else if (code_i >= tcw_pkg::CH_SPACE && code_i <= tcw_pkg::CH_LAST) begin
      wr_en = 1'b1;
      col_w = col_w + 1'b1;
    end

    // Wrap past the last column
    if (col_w >= (tcw_pkg::COL_W+1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end

    // Past the last row: scroll, stay on the bottom row
    if (row_w >= (tcw_pkg::ROW_W+1)'(ROWS)) begin
      scroll = 1'b1;
      row_w  = (tcw_pkg::ROW_W+1)'(ROWS - 1);
    end
  end

  assign step_o.col    = col_w[tcw_pkg::COL_W-1:0];
  assign step_o.row    = row_w[tcw_pkg::ROW_W-1:0];
  assign step_o.wr_en  = wr_en;
  assign step_o.scroll = scroll;

endmodule

FILE: hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
// Steps: a put of a control code or character, or an unused action, executes, then
//   raises done_o; a read adds a RAM read step; a clear blanks every cell; a put that
//   scrolls moves each row up and blanks the bottom row, set by the single screen RAM port pair.
// Throughput: one item at a time; start is taken again in the cycle done_o is high.
// Reset: cursor homes and the screen RAM is swept blank, one cell a cycle, with busy
//   high. Results cannot be stalled by the receiver.
module text_console_char_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item_i,
  output logic             done_o,
  output tcw_pkg::result_t result_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = (AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic [AW-1:0]              ptr_q;
  logic [AW-1:0]              waddr_q;
  logic                       pend_q;
  tcw_pkg::item_t             item_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::CELL_W-1:0] cell_q;
  logic                       done_q;
  tcw_pkg::result_t           result_q;

  tcw_pkg::cur_step_t         step;
  logic [XW-1:0]              loc;
  logic [XW-1:0]              idx_x;
  logic                       idx_ok;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // Cursor arithmetic
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col_i  (col_q),
    .row_i  (row_q),
    .code_i (item_q.char_code),
    .step_o (step)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Linear cursor location and read index check
  assign loc    = XW'(row_q) * XW'(COLUMNS) + XW'(col_q);
  assign idx_x  = XW'(item_q.cell_index);
  assign idx_ok = idx_x < XW'(CELLS);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    case (state_q)
      ST_INIT, ST_BLANK: begin
        ram_we = 1'b1;
      end
      ST_EXEC: begin
        if (item_q.action == tcw_pkg::ACT_PUT && step.wr_en) begin
          ram_we    = 1'b1;
          ram_waddr = loc[AW-1:0];
          ram_wdata = {item_q.bg_color, item_q.fg_color, item_q.char_code};
        end
        if (item_q.action == tcw_pkg::ACT_READ) begin
          ram_re    = 1'b1;
          ram_raddr = idx_x[AW-1:0];
        end
      end
      ST_SCROLL: begin
        // read one row down, write the previous read one row up
        ram_re    = 1'b1;
        ram_we    = pend_q;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
      end
      ST_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ptr_q    <= '0;
      waddr_q  <= '0;
      pend_q   <= 1'b0;
      item_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      cell_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == AW'(CELLS - 1)) begin
            ptr_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cell_q <= '0;
          case (item_q.action)
            tcw_pkg::ACT_PUT: begin
              col_q <= step.col;
              row_q <= step.row;
              if (step.scroll) begin
                ptr_q   <= AW'(COLUMNS);
                pend_q  <= 1'b0;
                state_q <= ST_SCROLL;
              end else begin
                state_q <= ST_DONE;
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              col_q   <= '0;
              row_q   <= '0;
              ptr_q   <= '0;
              state_q <= ST_BLANK;
            end
            tcw_pkg::ACT_READ: begin
              state_q <= ST_READ;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_READ: begin
          cell_q  <= idx_ok ? ram_rdata : '0;
          state_q <= ST_DONE;
        end
        ST_SCROLL: begin
          pend_q  <= 1'b1;
          waddr_q <= ptr_q - AW'(COLUMNS);
          ptr_q   <= ptr_q + 1'b1;
          if (ptr_q == AW'(CELLS - 1)) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          pend_q  <= 1'b0;
          ptr_q   <= AW'((ROWS - 1) * COLUMNS);
          state_q <= ST_BLANK;
        end
        ST_BLANK: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == AW'(CELLS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          done_q              <= 1'b1;
          result_q.cursor_pos <= loc[tcw_pkg::LOC_W-1:0];
          result_q.cell_value <= cell_q;
          state_q             <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < tcw_pkg::COL_W'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < tcw_pkg::ROW_W'(ROWS))
    else $error("cursor row out of range");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (XW'(ram_waddr) < XW'(CELLS)))
    else $error("screen write beyond last cell");

endmodule
